// File: design/pce_pkg.sv
// Shared types and constants for the correlation engine.
`default_nettype none

package pce_pkg;

  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned MAX_SAMPLES = 1024;
  localparam int unsigned CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SUM_W       = 27;
  localparam int unsigned SQ_W        = 41;
  localparam int unsigned XP_W        = 42;
  localparam int unsigned NA_W        = 52;
  localparam int unsigned NAB_W       = 54;
  localparam int unsigned MUL_W       = 56;
  localparam int unsigned MULP_W      = 2 * MUL_W;
  localparam int unsigned DIV_NUM_W   = 132;
  localparam int unsigned DIV_DEN_W   = 104;
  localparam int unsigned QUO_W       = 64;
  localparam int unsigned ROOT_ARG_W  = 48;
  localparam int unsigned ROOT_STEPS  = ROOT_ARG_W / 2;

  typedef struct packed {
    logic signed [15:0] sample_a;
    logic signed [15:0] sample_b;
    logic               last;
  } pce_item_t;

  typedef struct packed {
    logic [10:0]        sample_count;
    logic signed [23:0] mean_a;
    logic signed [23:0] mean_b;
    logic [38:0]        variance_a;
    logic [38:0]        variance_b;
    logic signed [39:0] covariance_ab;
    logic [23:0]        deviation_a;
    logic [23:0]        deviation_b;
    logic signed [15:0] correlation_ab;
    logic               degenerate;
    logic               overflow;
  } pce_result_t;

endpackage

`default_nettype wire

// File: design/pce_mul.sv
// Shift-and-add unsigned multiplier, one multiplier bit per cycle.
`default_nettype none

module pce_mul
  import pce_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [MUL_W-1:0]  op_a_i,
  input  logic [MUL_W-1:0]  op_b_i,
  output logic              done_o,
  output logic [MULP_W-1:0] product_o
);

  logic              busy_q, busy_d;
  logic [MULP_W-1:0] acc_q, acc_d;
  logic [MULP_W-1:0] mcand_q, mcand_d;
  logic [MUL_W-1:0]  mplier_q, mplier_d;

  always_comb begin
    busy_d   = busy_q;
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    done_o   = 1'b0;
    if (start_i) begin
      busy_d   = 1'b1;
      acc_d    = '0;
      mcand_d  = MULP_W'(op_a_i);
      mplier_d = op_b_i;
    end else if (busy_q) begin
      if (mplier_q == '0) begin
        // finish early once no multiplier bits remain
        done_o = 1'b1;
        busy_d = 1'b0;
      end else begin
        if (mplier_q[0]) acc_d = acc_q + mcand_q;
        mcand_d  = mcand_q << 1;
        mplier_d = mplier_q >> 1;
      end
    end
  end

  assign product_o = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
  end

endmodule

`default_nettype wire

// File: design/pce_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module pce_div
  import pce_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DIV_NUM_W-1:0] num_i,
  input  logic [DIV_DEN_W-1:0] den_i,
  output logic                 done_o,
  output logic [QUO_W-1:0]     quot_o
);

  localparam int unsigned CW = $clog2(DIV_NUM_W + 1);

  logic                 busy_q, busy_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [DIV_NUM_W-1:0] num_q, num_d;
  logic [DIV_DEN_W-1:0] den_q, den_d;
  logic [DIV_DEN_W-1:0] rem_q, rem_d;
  logic [QUO_W-1:0]     quo_q, quo_d;
  logic [DIV_DEN_W:0]   trial;
  logic                 fits;

  always_comb begin
    trial  = {rem_q, num_q[DIV_NUM_W-1]};
    fits   = trial >= {1'b0, den_q};
    busy_d = busy_q;
    cnt_d  = cnt_q;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    done_o = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(DIV_NUM_W);
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = fits ? DIV_DEN_W'(trial - {1'b0, den_q}) : DIV_DEN_W'(trial);
      num_d = num_q << 1;
      quo_d = {quo_q[QUO_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        done_o = 1'b1;
        busy_d = 1'b0;
      end
    end
  end

  assign quot_o = quo_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

endmodule

`default_nettype wire

// File: design/pearson_correlation_engine.sv
// Pearson correlation engine: running sums, then mean, variance, deviation,
// covariance and correlation of a set of sample pairs.
//
// A pair is taken when start_i is high and busy_o low. Each counted pair costs
// three passes of the shared shift-add multiplier; a pair beyond capacity is
// dropped and flags overflow, closing the set if it is the last. The closing
// pair then runs nine multiplies (each ends early once no multiplier bits
// remain), six divides on the shared restoring divider (five for a flat set),
// and three square roots. The result is shown for a single cycle with
// result_valid_o and cannot be held off; capture it then. busy_o is low again
// in that same cycle.
`default_nettype none

module pearson_correlation_engine
  import pce_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  pce_item_t   item_i,
  output logic        result_valid_o,
  output pce_result_t result_o
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ACC   = 5'b00010,
    ST_FMUL  = 5'b00100,
    ST_FDIV  = 5'b01000,
    ST_FROOT = 5'b10000
  } state_e;

  // micro-steps of the accumulate and closing sequences
  localparam logic [3:0] AS_AA     = 4'd0;
  localparam logic [3:0] AS_BB     = 4'd1;
  localparam logic [3:0] AS_AB     = 4'd2;
  localparam logic [3:0] MS_NSAA   = 4'd0;
  localparam logic [3:0] MS_SASA   = 4'd1;
  localparam logic [3:0] MS_NSBB   = 4'd2;
  localparam logic [3:0] MS_SBSB   = 4'd3;
  localparam logic [3:0] MS_NSAB   = 4'd4;
  localparam logic [3:0] MS_SASB   = 4'd5;
  localparam logic [3:0] MS_NN     = 4'd6;
  localparam logic [3:0] MS_NANB   = 4'd7;
  localparam logic [3:0] MS_NABSQ  = 4'd8;
  localparam logic [3:0] DS_MEANA  = 4'd0;
  localparam logic [3:0] DS_MEANB  = 4'd1;
  localparam logic [3:0] DS_VARA   = 4'd2;
  localparam logic [3:0] DS_VARB   = 4'd3;
  localparam logic [3:0] DS_COV    = 4'd4;
  localparam logic [3:0] DS_CORR   = 4'd5;
  localparam logic [3:0] RS_DEVA   = 4'd0;
  localparam logic [3:0] RS_DEVB   = 4'd1;
  localparam logic [3:0] RS_CORR   = 4'd2;

  localparam int unsigned RCW = $clog2(ROOT_STEPS + 1);

  state_e state_q, state_d;
  logic [3:0]  step_q, step_d;
  logic        go_q, go_d;

  logic signed [SAMPLE_W-1:0] a_q, a_d, b_q, b_d;
  logic        last_q, last_d;

  logic signed [SUM_W-1:0] sa_q, sa_d, sb_q, sb_d;
  logic [SQ_W-1:0]         saa_q, saa_d, sbb_q, sbb_d;
  logic signed [XP_W-1:0]  sab_q, sab_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic                    ovf_q, ovf_d;

  logic signed [NAB_W-1:0] t_q, t_d, nab_q, nab_d;
  logic [NA_W-1:0]         na_q, na_d, nb_q, nb_d;
  logic [2*CNT_W-2:0]      n2_q, n2_d;
  logic [DIV_DEN_W-1:0]    pp_q, pp_d, mm_q, mm_d;
  logic [23:0]             mean_a_q, mean_a_d, mean_b_q, mean_b_d;
  logic [ROOT_ARG_W-1:0]   sq_a_q, sq_a_d, sq_b_q, sq_b_d, carg_q, carg_d;
  logic [39:0]             cov_q, cov_d;
  logic [23:0]             dev_a_q, dev_a_d, dev_b_q, dev_b_d;

  logic [ROOT_ARG_W-1:0]   rx_q, rx_d, rres_q, rres_d, rbit_q, rbit_d;
  logic [RCW-1:0]          rcnt_q, rcnt_d;
  logic                    rrun_q, rrun_d;
  logic [ROOT_ARG_W-1:0]   rsum, rarg;
  logic                    rdone;

  pce_result_t res_q, res_d;
  logic        valid_q, valid_d;

  logic [MUL_W-1:0]     mul_a, mul_b;
  logic                 mul_go, mul_done;
  logic [MULP_W-1:0]    mul_p;
  logic signed [NAB_W-1:0] p54;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic                 div_go, div_done;
  logic [QUO_W-1:0]     div_q;

  logic [SAMPLE_W:0]    a_mag, b_mag;
  logic [SUM_W-1:0]     sa_mag, sb_mag;
  logic [XP_W-1:0]      sab_mag;
  logic [NAB_W-1:0]     nab_mag;
  logic                 a_neg, b_neg, sa_neg, sb_neg, nab_neg, degen, accept;

  assign accept  = start_i && !busy_o;
  assign busy_o  = state_q != ST_IDLE;

  assign a_neg   = a_q[SAMPLE_W-1];
  assign b_neg   = b_q[SAMPLE_W-1];
  assign a_mag   = a_neg ? (SAMPLE_W+1)'(-(SAMPLE_W+1)'(a_q)) : (SAMPLE_W+1)'(a_q);
  assign b_mag   = b_neg ? (SAMPLE_W+1)'(-(SAMPLE_W+1)'(b_q)) : (SAMPLE_W+1)'(b_q);
  assign sa_neg  = sa_q[SUM_W-1];
  assign sb_neg  = sb_q[SUM_W-1];
  assign sa_mag  = sa_neg ? SUM_W'(-sa_q) : SUM_W'(sa_q);
  assign sb_mag  = sb_neg ? SUM_W'(-sb_q) : SUM_W'(sb_q);
  assign sab_mag = sab_q[XP_W-1] ? XP_W'(-sab_q) : XP_W'(sab_q);
  assign nab_neg = nab_q[NAB_W-1];
  assign nab_mag = nab_neg ? NAB_W'(-nab_q) : NAB_W'(nab_q);
  assign degen   = (na_q == '0) || (nb_q == '0);
  assign p54     = signed'(mul_p[NAB_W-1:0]);

  // operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == ST_ACC) begin
      case (step_q)
        AS_AA:   begin mul_a = MUL_W'(a_mag); mul_b = MUL_W'(a_mag); end
        AS_BB:   begin mul_a = MUL_W'(b_mag); mul_b = MUL_W'(b_mag); end
        default: begin mul_a = MUL_W'(a_mag); mul_b = MUL_W'(b_mag); end
      endcase
    end else begin
      case (step_q)
        MS_NSAA:  begin mul_a = MUL_W'(cnt_q);   mul_b = MUL_W'(saa_q);   end
        MS_SASA:  begin mul_a = MUL_W'(sa_mag);  mul_b = MUL_W'(sa_mag);  end
        MS_NSBB:  begin mul_a = MUL_W'(cnt_q);   mul_b = MUL_W'(sbb_q);   end
        MS_SBSB:  begin mul_a = MUL_W'(sb_mag);  mul_b = MUL_W'(sb_mag);  end
        MS_NSAB:  begin mul_a = MUL_W'(cnt_q);   mul_b = MUL_W'(sab_mag); end
        MS_SASB:  begin mul_a = MUL_W'(sa_mag);  mul_b = MUL_W'(sb_mag);  end
        MS_NN:    begin mul_a = MUL_W'(cnt_q);   mul_b = MUL_W'(cnt_q);   end
        MS_NANB:  begin mul_a = MUL_W'(na_q);    mul_b = MUL_W'(nb_q);    end
        default:  begin mul_a = MUL_W'(nab_mag); mul_b = MUL_W'(nab_mag); end
      endcase
    end
  end

  // operand selection for the shared divider
  always_comb begin
    case (step_q)
      DS_MEANA: begin div_num = DIV_NUM_W'(sa_mag) << 8;  div_den = DIV_DEN_W'(cnt_q); end
      DS_MEANB: begin div_num = DIV_NUM_W'(sb_mag) << 8;  div_den = DIV_DEN_W'(cnt_q); end
      DS_VARA:  begin div_num = DIV_NUM_W'(na_q) << 16;   div_den = DIV_DEN_W'(n2_q);  end
      DS_VARB:  begin div_num = DIV_NUM_W'(nb_q) << 16;   div_den = DIV_DEN_W'(n2_q);  end
      DS_COV:   begin div_num = DIV_NUM_W'(nab_mag) << 8; div_den = DIV_DEN_W'(n2_q);  end
      default:  begin div_num = DIV_NUM_W'(mm_q) << 28;   div_den = pp_q;              end
    endcase
  end

  always_comb begin
    case (step_q)
      RS_DEVA: rarg = sq_a_q;
      RS_DEVB: rarg = sq_b_q;
      default: rarg = carg_q;
    endcase
  end

  assign mul_go = go_q && ((state_q == ST_ACC) || (state_q == ST_FMUL));
  assign div_go = go_q && (state_q == ST_FDIV);

  pce_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_go),
    .op_a_i    (mul_a),
    .op_b_i    (mul_b),
    .done_o    (mul_done),
    .product_o (mul_p)
  );

  pce_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_go),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_q)
  );

  // digit-by-digit square root, one result bit per cycle
  always_comb begin
    rsum   = rres_q + rbit_q;
    rx_d   = rx_q;
    rres_d = rres_q;
    rbit_d = rbit_q;
    rcnt_d = rcnt_q;
    rrun_d = rrun_q;
    rdone  = 1'b0;
    if (go_q && (state_q == ST_FROOT)) begin
      rx_d   = rarg;
      rres_d = '0;
      rbit_d = ROOT_ARG_W'(1) << (ROOT_ARG_W - 2);
      rcnt_d = RCW'(ROOT_STEPS);
      rrun_d = 1'b1;
    end else if (rrun_q) begin
      if (rx_q >= rsum) begin
        rx_d   = rx_q - rsum;
        rres_d = (rres_q >> 1) + rbit_q;
      end else begin
        rres_d = rres_q >> 1;
      end
      rbit_d = rbit_q >> 2;
      rcnt_d = rcnt_q - 1'b1;
      if (rcnt_q == RCW'(1)) begin
        rdone  = 1'b1;
        rrun_d = 1'b0;
      end
    end
  end

  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    go_d     = 1'b0;
    a_d      = a_q;
    b_d      = b_q;
    last_d   = last_q;
    sa_d     = sa_q;
    sb_d     = sb_q;
    saa_d    = saa_q;
    sbb_d    = sbb_q;
    sab_d    = sab_q;
    cnt_d    = cnt_q;
    ovf_d    = ovf_q;
    t_d      = t_q;
    na_d     = na_q;
    nb_d     = nb_q;
    nab_d    = nab_q;
    n2_d     = n2_q;
    pp_d     = pp_q;
    mm_d     = mm_q;
    mean_a_d = mean_a_q;
    mean_b_d = mean_b_q;
    sq_a_d   = sq_a_q;
    sq_b_d   = sq_b_q;
    cov_d    = cov_q;
    carg_d   = carg_q;
    dev_a_d  = dev_a_q;
    dev_b_d  = dev_b_q;
    res_d    = res_q;
    valid_d  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          a_d    = item_i.sample_a;
          b_d    = item_i.sample_b;
          last_d = item_i.last;
          step_d = '0;
          if (cnt_q < CNT_W'(MAX_SAMPLES)) begin
            state_d = ST_ACC;
            go_d    = 1'b1;
          end else begin
            // set full: drop the pair, close the set if asked
            ovf_d = 1'b1;
            if (item_i.last) begin
              state_d = ST_FMUL;
              go_d    = 1'b1;
            end
          end
        end
      end

      ST_ACC: begin
        if (mul_done) begin
          case (step_q)
            AS_AA:   saa_d = saa_q + SQ_W'(mul_p);
            AS_BB:   sbb_d = sbb_q + SQ_W'(mul_p);
            default: begin
              sab_d = (a_neg ^ b_neg) ? sab_q - XP_W'(mul_p) : sab_q + XP_W'(mul_p);
              sa_d  = sa_q + SUM_W'(a_q);
              sb_d  = sb_q + SUM_W'(b_q);
              cnt_d = cnt_q + 1'b1;
            end
          endcase
          if (step_q == AS_AB) begin
            step_d = '0;
            if (last_q) begin
              state_d = ST_FMUL;
              go_d    = 1'b1;
            end else begin
              state_d = ST_IDLE;
            end
          end else begin
            step_d = step_q + 1'b1;
            go_d   = 1'b1;
          end
        end
      end

      ST_FMUL: begin
        if (mul_done) begin
          case (step_q)
            MS_NSAA: t_d   = p54;
            MS_SASA: na_d  = NA_W'(t_q - p54);
            MS_NSBB: t_d   = p54;
            MS_SBSB: nb_d  = NA_W'(t_q - p54);
            MS_NSAB: t_d   = sab_q[XP_W-1] ? -p54 : p54;
            MS_SASB: nab_d = (sa_neg ^ sb_neg) ? t_q + p54 : t_q - p54;
            MS_NN:   n2_d  = mul_p[2*CNT_W-2:0];
            MS_NANB: pp_d  = mul_p[DIV_DEN_W-1:0];
            default: mm_d  = mul_p[DIV_DEN_W-1:0];
          endcase
          go_d = 1'b1;
          if (step_q == MS_NABSQ) begin
            state_d = ST_FDIV;
            step_d  = '0;
          end else begin
            step_d = step_q + 1'b1;
          end
        end
      end

      ST_FDIV: begin
        if (div_done) begin
          case (step_q)
            DS_MEANA: mean_a_d = div_q[23:0];
            DS_MEANB: mean_b_d = div_q[23:0];
            DS_VARA:  sq_a_d   = div_q[ROOT_ARG_W-1:0];
            DS_VARB:  sq_b_d   = div_q[ROOT_ARG_W-1:0];
            DS_COV:   cov_d    = div_q[39:0];
            default:  carg_d   = div_q[ROOT_ARG_W-1:0];
          endcase
          go_d = 1'b1;
          if ((step_q == DS_CORR) || ((step_q == DS_COV) && degen)) begin
            // flat set: skip the correlation divide, root of zero gives zero
            if (step_q == DS_COV) carg_d = '0;
            state_d = ST_FROOT;
            step_d  = '0;
          end else begin
            step_d = step_q + 1'b1;
          end
        end
      end

      ST_FROOT: begin
        if (rdone) begin
          case (step_q)
            RS_DEVA: dev_a_d = rres_d[23:0];
            RS_DEVB: dev_b_d = rres_d[23:0];
            default: begin
              res_d.sample_count   = cnt_q;
              res_d.mean_a         = sa_neg ? -signed'(mean_a_q) : signed'(mean_a_q);
              res_d.mean_b         = sb_neg ? -signed'(mean_b_q) : signed'(mean_b_q);
              res_d.variance_a     = sq_a_q[46:8];
              res_d.variance_b     = sq_b_q[46:8];
              res_d.covariance_ab  = nab_neg ? -signed'(cov_q) : signed'(cov_q);
              res_d.deviation_a    = dev_a_q;
              res_d.deviation_b    = dev_b_q;
              res_d.correlation_ab = nab_neg ? -signed'(rres_d[15:0]) : signed'(rres_d[15:0]);
              res_d.degenerate     = degen;
              res_d.overflow       = ovf_q;
              valid_d = 1'b1;
              // clear the set
              sa_d    = '0;
              sb_d    = '0;
              saa_d   = '0;
              sbb_d   = '0;
              sab_d   = '0;
              cnt_d   = '0;
              ovf_d   = 1'b0;
            end
          endcase
          if (step_q == RS_CORR) begin
            state_d = ST_IDLE;
            step_d  = '0;
          end else begin
            step_d = step_q + 1'b1;
            go_d   = 1'b1;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
        step_d  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      go_q    <= 1'b0;
      sa_q    <= '0;
      sb_q    <= '0;
      saa_q   <= '0;
      sbb_q   <= '0;
      sab_q   <= '0;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      rrun_q  <= 1'b0;
      rcnt_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      go_q    <= go_d;
      sa_q    <= sa_d;
      sb_q    <= sb_d;
      saa_q   <= saa_d;
      sbb_q   <= sbb_d;
      sab_q   <= sab_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      rrun_q  <= rrun_d;
      rcnt_q  <= rcnt_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q      <= a_d;
    b_q      <= b_d;
    last_q   <= last_d;
    t_q      <= t_d;
    na_q     <= na_d;
    nb_q     <= nb_d;
    nab_q    <= nab_d;
    n2_q     <= n2_d;
    pp_q     <= pp_d;
    mm_q     <= mm_d;
    mean_a_q <= mean_a_d;
    mean_b_q <= mean_b_d;
    sq_a_q   <= sq_a_d;
    sq_b_q   <= sq_b_d;
    cov_q    <= cov_d;
    carg_q   <= carg_d;
    dev_a_q  <= dev_a_d;
    dev_b_q  <= dev_b_d;
    rx_q     <= rx_d;
    rres_q   <= rres_d;
    rbit_q   <= rbit_d;
    res_q    <= res_d;
  end

  assign result_valid_o = valid_q;
  assign result_o       = res_q;

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for more than one cycle");

  a_idle_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (!busy_o && (cnt_q == '0) && !ovf_q))
    else $error("set not cleared when result given");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_SAMPLES))
    else $error("pair count beyond capacity");

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

endmodule

`default_nettype wire
